// File: rtl/ppi_mfe_pkg.sv
// ppi_mfe_pkg: types, codes, frame tables and the frame byte function of the
// ppi master frame engine. No dependencies.

package ppi_mfe_pkg;

  localparam int unsigned MaxWriteBytesDef = 208;
  localparam int unsigned ResponseBytesDef = 256;
  localparam int unsigned StepW            = 6;   // up to 37 results per item

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_WDATA = 2'd1,
    CMD_LINK  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_TX     = 2'd0,
    KIND_VALUE  = 2'd1,
    KIND_STATUS = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_BAD_AREA = 3'd1,
    ST_BAD_MODE = 3'd2,
    ST_NO_ACK   = 3'd3,
    ST_REJECTED = 3'd4
  } status_e;

  localparam logic [1:0] AREA_M   = 2'd0;
  localparam logic [1:0] AREA_V   = 2'd1;
  localparam logic [1:0] MODE_BIT = 2'd0;

  localparam logic [7:0] BYTE_ACK  = 8'hE5;
  localparam logic [7:0] BYTE_END  = 8'h16;
  localparam logic [7:0] BYTE_OK   = 8'hFF;

  localparam int unsigned HeadLen    = 22;
  localparam int unsigned ReadLen    = 33;
  localparam int unsigned WrHeadLen  = 35;
  localparam int unsigned WrFullLen  = 37;
  localparam int unsigned PollLen    = 6;
  localparam int unsigned ReadFcsIdx = 31;
  localparam int unsigned WrFcsIdx   = 35;

  localparam logic [7:0] READ_HEAD [HeadLen] = '{
    8'h68, 8'h1B, 8'h1B, 8'h68, 8'h02, 8'h00, 8'h6C, 8'h32, 8'h01, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h0E, 8'h00, 8'h00, 8'h04, 8'h01, 8'h12, 8'h0A, 8'h10};
  localparam logic [7:0] WRITE_HEAD [HeadLen] = '{
    8'h68, 8'h20, 8'h20, 8'h68, 8'h02, 8'h00, 8'h6C, 8'h32, 8'h01, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h0E, 8'h00, 8'h06, 8'h05, 8'h01, 8'h12, 8'h0A, 8'h10};
  localparam logic [7:0] MODE_CODE [4] = '{8'h01, 8'h02, 8'h04, 8'h06};
  localparam logic [7:0] POLL [PollLen] = '{8'h10, 8'h02, 8'h00, 8'h5C, 8'h5E, 8'h16};

  typedef struct packed {
    logic [1:0]  command;
    logic        is_write;
    logic [1:0]  area;
    logic [15:0] address;
    logic [7:0]  quantity;
    logic [1:0]  access_mode;
    logic [7:0]  data_byte;
  } item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  tx_byte;
    logic [31:0] read_value;
    logic [15:0] value_address;
    logic [2:0]  status;
    logic        last;
  } res_t;

  // request frame byte at position idx, fcs positions excluded
  function automatic logic [7:0] frame_byte(input logic wr, input logic [1:0] area,
                                            input logic [1:0] mode, input logic [15:0] addr,
                                            input logic [7:0] q, input logic [StepW-1:0] idx);
    logic [7:0]  b;
    logic [7:0]  head;
    logic [8:0]  plen;
    logic [10:0] bits;
    logic [23:0] off;
    logic        mb;
    head = '0;
    if (idx < StepW'(HeadLen)) begin
      head = wr ? WRITE_HEAD[idx[4:0]] : READ_HEAD[idx[4:0]];
    end
    plen = 9'(q) + 9'd4;
    bits = {q, 3'b000};
    off  = {5'b0, addr, 3'b000};
    mb   = (mode == MODE_BIT);
    case (idx)
      6'd1, 6'd2: b = wr ? (q + 8'd31) : head;
      6'd15:      b = wr ? {7'b0, plen[8]} : head;
      6'd16:      b = wr ? plen[7:0] : head;
      6'd22:      b = MODE_CODE[mode];
      6'd24:      b = (wr && mb) ? 8'h01 : q;
      6'd26:      b = (area == AREA_V) ? 8'h01 : 8'h00;
      6'd27:      b = (area == AREA_V) ? 8'h84 : 8'h83;
      6'd28:      b = off[23:16];
      6'd29:      b = off[15:8];
      6'd30:      b = off[7:0];
      6'd32:      b = wr ? (mb ? 8'h03 : 8'h04) : BYTE_END;
      6'd33:      b = (wr && !mb) ? {5'b0, bits[10:8]} : 8'h00;
      6'd34:      b = wr ? (mb ? 8'h01 : bits[7:0]) : 8'h00;
      6'd36:      b = BYTE_END;
      default:    b = (idx < StepW'(HeadLen)) ? head : 8'h00;
    endcase
    return b;
  endfunction

endpackage

// File: rtl/ppi_mfe_inreg.sv
// ppi_mfe_inreg: input register holding one accepted item until the core
// has finished with it. Depends on ppi_mfe_pkg.

module ppi_mfe_inreg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                stall_o,
  input  ppi_mfe_pkg::item_t  item_i,
  input  logic                consume_i,
  output logic                item_valid_o,
  output ppi_mfe_pkg::item_t  item_o
);
  import ppi_mfe_pkg::*;

  logic  valid_q;
  item_t item_q;
  logic  load;

  assign stall_o = valid_q && !consume_i;
  assign load    = valid_i && !stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= 1'b1;
    end else if (consume_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= item_i;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

// File: rtl/ppi_mfe_outreg.sv
// ppi_mfe_outreg: result register between the core and the output channel.
// Depends on ppi_mfe_pkg.

module ppi_mfe_outreg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  ppi_mfe_pkg::res_t  res_i,
  output logic               ready_o,
  output logic               valid_o,
  input  logic               stall_i,
  output ppi_mfe_pkg::res_t  res_o
);
  import ppi_mfe_pkg::*;

  logic valid_q;
  res_t res_q;

  assign ready_o = !valid_q || !stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && load_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

// File: rtl/ppi_mfe_core.sv
// ppi_mfe_core: protocol state and result sequencer; walks the results of
// the held item one per cycle when not stalled. Depends on ppi_mfe_pkg.

module ppi_mfe_core #(
  parameter int unsigned MAX_WRITE_BYTES = ppi_mfe_pkg::MaxWriteBytesDef,
  parameter int unsigned RESPONSE_BYTES  = ppi_mfe_pkg::ResponseBytesDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               item_valid_i,
  input  ppi_mfe_pkg::item_t item_i,
  input  logic               out_ready_i,
  output logic               consume_o,
  output logic               res_load_o,
  output ppi_mfe_pkg::res_t  res_o
);
  import ppi_mfe_pkg::*;

  localparam int unsigned IdxW   = $clog2(RESPONSE_BYTES + 1);
  localparam logic [12:0] MaxLen = 13'(RESPONSE_BYTES - 25);

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_WDATA = 3'd1,
    PH_ACK   = 3'd2,
    PH_RESP  = 3'd3
  } phase_e;

  phase_e           phase_q;
  logic             op_wr_q;
  logic [1:0]       op_mode_q;
  logic [15:0]      op_addr_q;
  logic [7:0]       bytes_left_q;
  logic [7:0]       tx_ck_q;
  logic [IdxW-1:0]  rx_idx_q;
  logic [7:0]       rx_ck_q;
  logic [12:0]      dlen_q;
  logic [31:0]      vshift_q;
  logic [15:0]      vcount_q;
  logic [StepW-1:0] step_q;

  logic [StepW-1:0] n_res;
  res_t             res;
  logic [7:0]       b;
  logic [7:0]       qsat;
  logic             fire, last_step;
  // response decode
  logic [1:0]       lg, mask, k;
  logic [13:0]      len_raw;
  logic [12:0]      len_cl;
  logic [12:0]      groups_new, groups_q;
  logic             grp_end, vals_done, reject;
  logic [31:0]      val;

  assign b    = item_i.data_byte;
  assign qsat = (item_i.quantity > 8'(MAX_WRITE_BYTES)) ? 8'(MAX_WRITE_BYTES)
                                                         : item_i.quantity;

  always_comb begin
    lg         = op_mode_q - 2'd1;
    mask       = (2'd1 << lg) - 2'd1;
    k          = 2'(rx_idx_q - IdxW'(25)) & mask;
    len_raw    = 14'(dlen_q) + 14'(b[7:3]);
    len_cl     = (len_raw > 14'(MaxLen)) ? MaxLen : len_raw[12:0];
    groups_new = len_cl >> lg;
    groups_q   = dlen_q >> lg;
    grp_end    = (k == mask);
    vals_done  = (17'(vcount_q) + 17'd1) >= 17'(groups_q);
    val        = vshift_q | (32'(b) << {k, 3'b000});
    reject     = (rx_idx_q == IdxW'(21)) && (b != BYTE_OK);
  end

  // result count and the result at the current step
  always_comb begin
    n_res = '0;
    res   = '0;
    case (item_i.command)
      CMD_START: begin
        if (item_i.area != AREA_M && item_i.area != AREA_V) begin
          n_res = 6'd1;
          res.kind = KIND_STATUS;
          res.status = ST_BAD_AREA;
        end else if (!item_i.is_write) begin
          n_res = 6'(ReadLen);
          res.kind = KIND_TX;
          res.tx_byte = (step_q == 6'(ReadFcsIdx)) ? tx_ck_q :
              frame_byte(1'b0, item_i.area, item_i.access_mode, item_i.address,
                         item_i.quantity, step_q);
        end else if (item_i.access_mode > 2'd1) begin
          n_res = 6'd1;
          res.kind = KIND_STATUS;
          res.status = ST_BAD_MODE;
        end else begin
          n_res = (qsat == 8'd0) ? 6'(WrFullLen) : 6'(WrHeadLen);
          res.kind = KIND_TX;
          res.tx_byte = (step_q == 6'(WrFcsIdx)) ? tx_ck_q :
              frame_byte(1'b1, item_i.area, item_i.access_mode, item_i.address,
                         qsat, step_q);
        end
      end
      CMD_WDATA: begin
        if (phase_q == PH_WDATA) begin
          n_res = (bytes_left_q == 8'd1) ? 6'd3 : 6'd1;
          res.kind = KIND_TX;
          case (step_q)
            6'd0:    res.tx_byte = b;
            6'd1:    res.tx_byte = tx_ck_q;
            default: res.tx_byte = BYTE_END;
          endcase
        end
      end
      CMD_LINK: begin
        if (phase_q == PH_ACK) begin
          if (b == BYTE_ACK) begin
            n_res = 6'(PollLen);
            res.kind = KIND_TX;
            res.tx_byte = (step_q < 6'(PollLen)) ? POLL[step_q[2:0]] : 8'h00;
          end else begin
            n_res = 6'd1;
            res.kind = KIND_STATUS;
            res.status = ST_NO_ACK;
          end
        end else if (phase_q == PH_RESP) begin
          res.kind = KIND_STATUS;
          if (reject) begin
            n_res = 6'd1;
            res.status = ST_REJECTED;
          end else if (op_wr_q) begin
            if (rx_idx_q == IdxW'(22)) begin
              n_res = 6'd1;
              res.status = (b == rx_ck_q) ? ST_OK : ST_REJECTED;
            end
          end else if (op_mode_q == MODE_BIT) begin
            if (rx_idx_q == IdxW'(25)) begin
              n_res = 6'd2;
              if (step_q == 6'd0) begin
                res.kind = KIND_VALUE;
                res.read_value = {31'b0, b[0]};
                res.value_address = op_addr_q;
              end
            end
          end else if (rx_idx_q == IdxW'(24)) begin
            if (groups_new == '0) begin
              n_res = 6'd1;
            end
          end else if (rx_idx_q >= IdxW'(25) && grp_end) begin
            n_res = vals_done ? 6'd2 : 6'd1;
            if (step_q == 6'd0) begin
              res.kind = KIND_VALUE;
              res.read_value = val;
              res.value_address = op_addr_q + vcount_q;
            end
          end
        end
      end
      default: n_res = '0;
    endcase
    res.last = (step_q == n_res - 6'd1);
  end

  assign last_step  = (step_q == n_res - 6'd1);
  assign fire       = item_valid_i && (n_res != '0) && out_ready_i;
  assign consume_o  = item_valid_i && ((n_res == '0) || (out_ready_i && last_step));
  assign res_load_o = fire;
  assign res_o      = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_IDLE;
      op_wr_q      <= 1'b0;
      op_mode_q    <= '0;
      op_addr_q    <= '0;
      bytes_left_q <= '0;
      tx_ck_q      <= '0;
      rx_idx_q     <= '0;
      rx_ck_q      <= '0;
      dlen_q       <= '0;
      vshift_q     <= '0;
      vcount_q     <= '0;
      step_q       <= '0;
    end else begin
      if (fire) begin
        step_q <= last_step ? '0 : step_q + 6'd1;
        // running fcs of the frame being sent
        if (item_i.command == CMD_START) begin
          if (step_q == '0) begin
            tx_ck_q <= '0;
          end else if (step_q >= 6'd4 && step_q < 6'(WrHeadLen)) begin
            tx_ck_q <= tx_ck_q + res.tx_byte;
          end
        end else if (item_i.command == CMD_WDATA && step_q == '0) begin
          tx_ck_q <= tx_ck_q + b;
        end
      end
      if (consume_o) begin
        case (item_i.command)
          CMD_START: begin
            phase_q <= PH_IDLE;
            if (item_i.area == AREA_M || item_i.area == AREA_V) begin
              op_wr_q   <= item_i.is_write;
              op_mode_q <= item_i.access_mode;
              op_addr_q <= item_i.address;
              if (!item_i.is_write) begin
                phase_q <= PH_ACK;
              end else if (item_i.access_mode <= 2'd1) begin
                bytes_left_q <= qsat;
                phase_q      <= (qsat == 8'd0) ? PH_ACK : PH_WDATA;
              end
            end
          end
          CMD_WDATA: begin
            if (phase_q == PH_WDATA) begin
              bytes_left_q <= bytes_left_q - 8'd1;
              if (bytes_left_q == 8'd1) begin
                phase_q <= PH_ACK;
              end
            end
          end
          CMD_LINK: begin
            if (phase_q == PH_ACK) begin
              if (b == BYTE_ACK) begin
                rx_idx_q <= '0;
                rx_ck_q  <= '0;
                phase_q  <= PH_RESP;
              end else begin
                phase_q <= PH_IDLE;
              end
            end else if (phase_q == PH_RESP) begin
              rx_idx_q <= rx_idx_q + IdxW'(1);
              if (reject) begin
                phase_q <= PH_IDLE;
              end else if (op_wr_q) begin
                if (rx_idx_q >= IdxW'(4) && rx_idx_q <= IdxW'(20)) begin
                  rx_ck_q <= rx_ck_q + b;
                end
                if (rx_idx_q == IdxW'(22)) begin
                  phase_q <= PH_IDLE;
                end
              end else if (op_mode_q == MODE_BIT) begin
                if (rx_idx_q == IdxW'(25)) begin
                  phase_q <= PH_IDLE;
                end
              end else if (rx_idx_q == IdxW'(23)) begin
                dlen_q <= {b, 5'b0};
              end else if (rx_idx_q == IdxW'(24)) begin
                dlen_q   <= len_cl;
                vshift_q <= '0;
                vcount_q <= '0;
                if (groups_new == '0) begin
                  phase_q <= PH_IDLE;
                end
              end else if (rx_idx_q >= IdxW'(25)) begin
                if (grp_end) begin
                  vshift_q <= '0;
                  vcount_q <= vcount_q + 16'd1;
                  if (vals_done) begin
                    phase_q <= PH_IDLE;
                  end
                end else begin
                  vshift_q <= val;
                end
              end
            end
          end
          default: ;
        endcase
      end
    end
  end

  a_wdata_has_bytes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_WDATA |-> bytes_left_q != 8'd0)
    else $error("write data phase with no bytes left");

  a_step_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !item_valid_i |-> step_q == '0)
    else $error("result step not cleared without an item");

  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && last_step |=> step_q == '0)
    else $error("result step not cleared after last beat");

  a_fire_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && last_step |-> consume_o)
    else $error("item kept after its last result");

endmodule

// File: rtl/ppi_master_frame_engine.sv
// ppi_master_frame_engine: top level of the ppi master frame engine.
// Depends on ppi_mfe_pkg, ppi_mfe_inreg, ppi_mfe_core, ppi_mfe_outreg.
//
//   channel | direction | handshake             | payload
//   req     | in        | req_valid_i/stall_o   | command .. data_byte
//   res     | out       | res_valid_o/stall_i   | kind .. last
//
// an item yields 0 to 37 result beats, one per cycle when not stalled;
// a request frame is 33 to 37 beats, set by the core's single result sequencer.
// the next item is taken at the edge where its predecessor's last beat
// enters the result register; an item with no beats is consumed without a result.
// reset clears protocol state, the input and the result register valids.
// a stalled result holds the sequencer and any input item with beats.

module ppi_master_frame_engine #(
  parameter int unsigned MAX_WRITE_BYTES = ppi_mfe_pkg::MaxWriteBytesDef,
  parameter int unsigned RESPONSE_BYTES  = ppi_mfe_pkg::ResponseBytesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        req_valid_i,
  output logic        req_stall_o,
  input  logic [1:0]  command_i,
  input  logic        is_write_i,
  input  logic [1:0]  area_i,
  input  logic [15:0] address_i,
  input  logic [7:0]  quantity_i,
  input  logic [1:0]  access_mode_i,
  input  logic [7:0]  data_byte_i,
  output logic        res_valid_o,
  input  logic        res_stall_i,
  output logic [1:0]  kind_o,
  output logic [7:0]  tx_byte_o,
  output logic [31:0] read_value_o,
  output logic [15:0] value_address_o,
  output logic [2:0]  status_o,
  output logic        last_o
);
  import ppi_mfe_pkg::*;

  item_t in_item, held_item;
  logic  held_valid, consume, res_load, out_ready;
  res_t  core_res, out_res;

  assign in_item = '{command: command_i, is_write: is_write_i, area: area_i,
                     address: address_i, quantity: quantity_i,
                     access_mode: access_mode_i, data_byte: data_byte_i};

  ppi_mfe_inreg u_inreg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (req_valid_i),
    .stall_o      (req_stall_o),
    .item_i       (in_item),
    .consume_i    (consume),
    .item_valid_o (held_valid),
    .item_o       (held_item)
  );

  ppi_mfe_core #(
    .MAX_WRITE_BYTES (MAX_WRITE_BYTES),
    .RESPONSE_BYTES  (RESPONSE_BYTES)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (held_valid),
    .item_i       (held_item),
    .out_ready_i  (out_ready),
    .consume_o    (consume),
    .res_load_o   (res_load),
    .res_o        (core_res)
  );

  ppi_mfe_outreg u_outreg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (res_load),
    .res_i   (core_res),
    .ready_o (out_ready),
    .valid_o (res_valid_o),
    .stall_i (res_stall_i),
    .res_o   (out_res)
  );

  assign kind_o          = out_res.kind;
  assign tx_byte_o       = out_res.tx_byte;
  assign read_value_o    = out_res.read_value;
  assign value_address_o = out_res.value_address;
  assign status_o        = out_res.status;
  assign last_o          = out_res.last;

endmodule
